[rtl/dst_pkg.sv]
// Package for the source tokenizer: token and mode types, kind codes,
// saturation helpers, character classes and the keyword table. No dependencies.
package dst_pkg;

    localparam int SOURCE_BYTES = 65536;
    localparam int KW_MAX_LEN = 9;
    localparam int KW_COUNT = 16;
    localparam int MAX_TOKS = 4;
    localparam logic [15:0] CAP16 = 16'hFFFF;
    localparam logic [15:0] POS_MAX = (SOURCE_BYTES - 1 < 65535) ?
                                      16'(SOURCE_BYTES - 1) : 16'hFFFF;

    // Character codes of the eight-letter mesh layer keyword.
    localparam logic [63:0] KW_MESH = 64'h6d7a_695f_6d65_7368;

    localparam logic [4:0] K_EOF   = 5'd0;
    localparam logic [4:0] K_ERR   = 5'd1;
    localparam logic [4:0] K_IDENT = 5'd2;
    localparam logic [4:0] K_NUM   = 5'd3;
    localparam logic [4:0] K_STR   = 5'd4;
    localparam logic [4:0] K_DOT   = 5'd13;
    localparam logic [4:0] K_MINUS = 5'd16;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_STRING, M_STR_ESC, M_IDENT, M_NUM_INT,
        M_NUM_DOT, M_NUM_FRAC, M_NUM_E, M_NUM_EPLUS, M_NUM_EMINUS, M_NUM_EXP
    } t_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] offset;
        logic [15:0] size;
        logic [15:0] line;
    } t_tok;

    typedef logic [KW_MAX_LEN-1:0][7:0] t_chars;

    function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b,
                                            logic [15:0] cap);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, cap}) ? cap : s[15:0];
    endfunction

    function automatic logic letter_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic decimal_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [4:0] punct_kind(logic [7:0] c);
        case (c)
            "{": return 5'd5;
            "}": return 5'd6;
            "(": return 5'd7;
            ")": return 5'd8;
            "[": return 5'd9;
            "]": return 5'd10;
            ":": return 5'd11;
            ",": return 5'd12;
            ".": return K_DOT;
            ";": return 5'd14;
            "=": return 5'd15;
            "-": return K_MINUS;
            default: return 5'd0;
        endcase
    endfunction

    // Keyword text is right aligned: the last character sits in bits 7:0.
    function automatic logic [71:0] kw_text(int i);
        case (i)
            0:  return 72'("photon");
            1:  return 72'("network");
            2:  return 72'("lens");
            3:  return 72'("waveguide");
            4:  return 72'("layer");
            5:  return 72'(KW_MESH);
            6:  return 72'("readout");
            7:  return 72'("train");
            8:  return 72'("optical");
            9:  return 72'("forward");
            10: return 72'("interfere");
            11: return 72'("through");
            12: return 72'("activate");
            13: return 72'("as");
            14: return 72'("emit");
            default: return 72'("with");
        endcase
    endfunction

    function automatic int kw_len(int i);
        case (i)
            0: return 6;  1: return 7;  2: return 4;  3: return 9;
            4: return 5;  5: return 8;  6: return 7;  7: return 5;
            8: return 7;  9: return 7;  10: return 9; 11: return 7;
            12: return 8; 13: return 2; 14: return 4;
            default: return 4;
        endcase
    endfunction

    function automatic logic [4:0] kw_kind(int i);
        case (i)
            0: return 5'd17;  1: return 5'd18;  2: return 5'd19;  3: return 5'd19;
            4: return 5'd20;  5: return 5'd20;  6: return 5'd21;  7: return 5'd22;
            8: return 5'd23;  9: return 5'd24;  10: return 5'd25; 11: return 5'd26;
            12: return 5'd27; 13: return 5'd28; 14: return 5'd29;
            default: return 5'd30;
        endcase
    endfunction

    // All sixteen entries are compared side by side; at most one can match.
    function automatic logic [4:0] kw_lookup(t_chars chars, logic [15:0] len);
        logic [4:0]  kind;
        logic        hit;
        logic [71:0] txt;
        int          n;
        kind = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            txt = kw_text(i);
            n = kw_len(i);
            hit = (len == 16'(n));
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (j < n && chars[j] != txt[8*(n-1-j) +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = kw_kind(i);
            end
        end
        return kind;
    endfunction

    function automatic t_tok mk_tok(logic [4:0] kind, logic [15:0] off,
                                    logic [15:0] size, logic [15:0] line);
        t_tok t;
        t.kind = kind;
        t.offset = off;
        t.size = size;
        t.line = line;
        return t;
    endfunction

endpackage

[rtl/dst_scanner.sv]
// Scanner state and the per-byte step: turns one accepted byte into up to four tokens.
// Depends on dst_pkg.
module dst_scanner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [7:0]                     i_byte,
    output dst_pkg::t_tok [dst_pkg::MAX_TOKS-1:0] o_toks,
    output logic [2:0]                     o_count
);
    import dst_pkg::*;

    t_mode       r_mode, n_mode;
    logic [15:0] r_bp, n_bp;
    logic [15:0] r_lc, n_lc;
    logic [15:0] r_ps, n_ps;
    logic [15:0] r_pl, n_pl;
    logic [15:0] r_il, n_il;
    t_chars      r_chars, n_chars;

    always_comb begin
        logic [7:0]  c;
        logic        dig;
        logic        ise;
        logic [15:0] p1;
        logic        go_idle;
        logic        go_ident;
        logic        eof;
        logic [2:0]  k;
        t_tok [MAX_TOKS-1:0] toks;

        c = i_byte;
        dig = decimal_char(c);
        ise = (c == "e") || (c == "E");
        p1 = sat_add(r_ps, r_il, POS_MAX);
        go_idle = 1'b0;
        go_ident = 1'b0;
        eof = 1'b0;
        k = 3'd0;
        toks = '0;
        n_mode = r_mode;
        n_bp = r_bp;
        n_lc = r_lc;
        n_ps = r_ps;
        n_pl = r_pl;
        n_il = r_il;
        n_chars = r_chars;

        case (r_mode)
            M_SLASH: begin
                if (c == "/") begin
                    n_mode = M_COMMENT;
                end else begin
                    toks[k[1:0]] = mk_tok(K_ERR, r_ps, 16'd1, r_pl);
                    k = k + 3'd1;
                    go_idle = 1'b1;
                end
            end
            M_COMMENT: begin
                if (c == "\n") begin
                    n_lc = sat_add(r_lc, 16'd1, CAP16);
                    n_mode = M_IDLE;
                end else if (c == 8'd0) begin
                    go_idle = 1'b1;
                end
            end
            M_STRING, M_STR_ESC: begin
                if (c == 8'd0 || (r_mode == M_STRING && c == "\"")) begin
                    toks[k[1:0]] = mk_tok(K_STR, r_ps, r_il, r_pl);
                    k = k + 3'd1;
                    if (c == 8'd0) begin
                        go_idle = 1'b1;
                    end else begin
                        n_mode = M_IDLE;
                    end
                end else begin
                    if (r_mode == M_STRING && c == "\\") begin
                        n_mode = M_STR_ESC;
                    end else if (r_mode == M_STR_ESC) begin
                        n_mode = M_STRING;
                    end else if (c == "\n") begin
                        n_lc = sat_add(r_lc, 16'd1, CAP16);
                    end
                    n_il = sat_add(r_il, 16'd1, CAP16);
                end
            end
            M_IDENT: begin
                go_ident = 1'b1;
            end
            M_NUM_INT, M_NUM_FRAC, M_NUM_EXP: begin
                if (dig) begin
                    n_il = sat_add(r_il, 16'd1, CAP16);
                end else if (r_mode == M_NUM_INT && c == ".") begin
                    n_mode = M_NUM_DOT;
                end else if (r_mode != M_NUM_EXP && ise) begin
                    n_chars[0] = c;
                    n_mode = M_NUM_E;
                end else begin
                    toks[k[1:0]] = mk_tok(K_NUM, r_ps, r_il, r_pl);
                    k = k + 3'd1;
                    go_idle = 1'b1;
                end
            end
            M_NUM_DOT: begin
                if (dig) begin
                    n_il = sat_add(r_il, 16'd2, CAP16);
                    n_mode = M_NUM_FRAC;
                end else begin
                    toks[k[1:0]] = mk_tok(K_NUM, r_ps, r_il, r_pl);
                    k = k + 3'd1;
                    toks[k[1:0]] = mk_tok(K_DOT, p1, 16'd1, r_pl);
                    k = k + 3'd1;
                    go_idle = 1'b1;
                end
            end
            M_NUM_E: begin
                if (dig) begin
                    n_il = sat_add(r_il, 16'd2, CAP16);
                    n_mode = M_NUM_EXP;
                end else if (c == "+") begin
                    n_mode = M_NUM_EPLUS;
                end else if (c == "-") begin
                    n_mode = M_NUM_EMINUS;
                end else begin
                    // The held-back e becomes the first character of an identifier.
                    toks[k[1:0]] = mk_tok(K_NUM, r_ps, r_il, r_pl);
                    k = k + 3'd1;
                    n_ps = p1;
                    n_il = 16'd1;
                    go_ident = 1'b1;
                end
            end
            M_NUM_EPLUS, M_NUM_EMINUS: begin
                if (dig) begin
                    n_il = sat_add(r_il, 16'd3, CAP16);
                    n_mode = M_NUM_EXP;
                end else begin
                    toks[k[1:0]] = mk_tok(K_NUM, r_ps, r_il, r_pl);
                    k = k + 3'd1;
                    toks[k[1:0]] = mk_tok(K_IDENT, p1, 16'd1, r_pl);
                    k = k + 3'd1;
                    toks[k[1:0]] = mk_tok((r_mode == M_NUM_EPLUS) ? K_ERR : K_MINUS,
                                          sat_add(p1, 16'd1, POS_MAX), 16'd1, r_pl);
                    k = k + 3'd1;
                    go_idle = 1'b1;
                end
            end
            default: begin
                go_idle = 1'b1;
            end
        endcase

        if (go_ident) begin
            if (letter_char(c) || dig) begin
                if (n_il < 16'(KW_MAX_LEN)) begin
                    n_chars[n_il[3:0]] = c;
                end
                n_il = sat_add(n_il, 16'd1, CAP16);
                n_mode = M_IDENT;
            end else begin
                toks[k[1:0]] = mk_tok(kw_lookup(n_chars, n_il), n_ps, n_il, r_pl);
                k = k + 3'd1;
                go_idle = 1'b1;
            end
        end

        if (go_idle) begin
            n_mode = M_IDLE;
            if (c == 8'd0) begin
                toks[k[1:0]] = mk_tok(K_EOF, r_bp, 16'd0, n_lc);
                k = k + 3'd1;
                eof = 1'b1;
                n_bp = 16'd0;
                n_lc = 16'd1;
                n_ps = 16'd0;
                n_pl = 16'd1;
                n_il = 16'd0;
            end else if (c == " " || c == "\t" || c == "\r") begin
                n_mode = M_IDLE;
            end else if (c == "\n") begin
                n_lc = sat_add(n_lc, 16'd1, CAP16);
            end else if (c == "\"") begin
                n_mode = M_STRING;
                n_ps = sat_add(r_bp, 16'd1, POS_MAX);
                n_pl = n_lc;
                n_il = 16'd0;
            end else if (c == "/") begin
                n_mode = M_SLASH;
                n_ps = r_bp;
                n_pl = n_lc;
                n_il = 16'd0;
            end else if (punct_kind(c) != 5'd0) begin
                toks[k[1:0]] = mk_tok(punct_kind(c), r_bp, 16'd1, n_lc);
                k = k + 3'd1;
            end else if (letter_char(c)) begin
                n_mode = M_IDENT;
                n_ps = r_bp;
                n_pl = n_lc;
                n_chars[0] = c;
                n_il = 16'd1;
            end else if (dig) begin
                n_mode = M_NUM_INT;
                n_ps = r_bp;
                n_pl = n_lc;
                n_il = 16'd1;
            end else begin
                toks[k[1:0]] = mk_tok(K_ERR, r_bp, 16'd1, n_lc);
                k = k + 3'd1;
            end
        end

        if (!eof) begin
            n_bp = sat_add(r_bp, 16'd1, POS_MAX);
        end
        o_toks = toks;
        o_count = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_bp <= 16'd0;
            r_lc <= 16'd1;
            r_ps <= 16'd0;
            r_pl <= 16'd1;
            r_il <= 16'd0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_bp <= n_bp;
            r_lc <= n_lc;
            r_ps <= n_ps;
            r_pl <= n_pl;
            r_il <= n_il;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_chars <= n_chars;
        end
    end

endmodule

[rtl/dsl_source_tokenizer.sv]
// Top level of the source tokenizer: scanner plus a four-token result buffer.
// Depends on dst_pkg and dst_scanner.
//
// Source bytes enter one per cycle; a zero byte ends the source and resets the
// position and line counters. Each byte yields zero to four tokens, which are
// held in a result buffer and handed out one per word, with o_run_last set on
// the last token of a byte. A byte is taken whenever the buffer is empty or is
// giving up its final token in the same cycle, so a stream in which each byte
// yields at most one token runs at one byte per cycle while the receiver is ready;
// a byte that yields more tokens holds the input while they drain.
module dsl_source_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_offset,
    output logic [15:0] o_token_size,
    output logic [15:0] o_token_line,
    output logic        o_run_last
);
    import dst_pkg::*;

    t_tok [MAX_TOKS-1:0] scan_toks;
    logic [2:0]          scan_count;
    logic                take;
    logic                pop;
    t_tok [MAX_TOKS-1:0] r_buf;
    logic [2:0]          r_left;
    logic [1:0]          r_idx;
    t_tok                head;

    assign pop = o_valid && i_ready;
    assign o_ready = (r_left == 3'd0) || (r_left == 3'd1 && i_ready);
    assign take = i_valid && o_ready;

    dst_scanner u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_source_byte),
        .o_toks  (scan_toks),
        .o_count (scan_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_idx <= 2'd0;
        end else if (take) begin
            r_left <= scan_count;
            r_idx <= 2'd0;
        end else if (pop) begin
            r_left <= r_left - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_buf <= scan_toks;
        end
    end

    assign head = r_buf[r_idx];
    assign o_valid = (r_left != 3'd0);
    assign o_run_last = (r_left == 3'd1);
    assign o_token_kind = head.kind;
    assign o_token_offset = head.offset;
    assign o_token_size = head.size;
    assign o_token_line = head.line;

endmodule

[bench/tb.sv]
// Testbench for dsl_source_tokenizer: drives source bytes and checks every token word.
// Depends on dst_pkg and the tokenizer RTL; a built-in scanner predicts the tokens.
`timescale 1ns / 1ps

module tb;
    import dst_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_source_byte = 8'd0;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_run_last;
    logic [4:0]  o_token_kind;
    logic [15:0] o_token_offset, o_token_size, o_token_line;

    dsl_source_tokenizer uut (.*);

    always #4 i_clk = ~i_clk;

    typedef struct {
        logic [4:0]  kind;
        logic [15:0] offset;
        logic [15:0] size;
        logic [15:0] line;
        logic        last;
    } t_tok_word;

    t_tok_word   pending_tokens[$];
    t_tok_word   byte_tokens[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          sent_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // Scanner state of the predictor.
    t_mode       sc_mode = M_IDLE;
    logic [15:0] sc_pos = 16'd0, sc_line = 16'd1, sc_start = 16'd0;
    logic [15:0] sc_start_line = 16'd1, sc_len = 16'd0;
    logic [7:0]  sc_chars[KW_MAX_LEN];
    logic        sc_eof;

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic logic [15:0] cap_add(logic [15:0] a, int b, logic [15:0] lim);
        int s;
        s = int'(a) + b;
        return (s > int'(lim)) ? lim : 16'(s);
    endfunction

    function automatic logic alpha_c(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic digit_c(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [4:0] punct_c(logic [7:0] c);
        string p;
        p = "{}()[]:,.;=-";
        for (int i = 0; i < 12; i++) if (p[i] == c) return 5'(5 + i);
        return 5'd0;
    endfunction

    function automatic logic [4:0] word_kind();
        string kw[16];
        int    kk[16];
        logic  hit;
        kw = '{"photon", "network", "lens", "waveguide", "layer",
               $sformatf("%s", KW_MESH),
               "readout", "train", "optical", "forward", "interfere", "through",
               "activate", "as", "emit", "with"};
        kk = '{17, 18, 19, 19, 20, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30};
        if (sc_len > KW_MAX_LEN) return K_IDENT;
        for (int i = 0; i < 16; i++) begin
            hit = (kw[i].len() == int'(sc_len));
            for (int j = 0; j < kw[i].len(); j++)
                if (hit && sc_chars[j] != kw[i][j]) hit = 1'b0;
            if (hit) return 5'(kk[i]);
        end
        return K_IDENT;
    endfunction

    function automatic void add_token(logic [4:0] k, logic [15:0] o, logic [15:0] s,
                                      logic [15:0] l);
        t_tok_word t;
        t.kind = k; t.offset = o; t.size = s; t.line = l; t.last = 1'b0;
        if (byte_tokens.size() < MAX_TOKS) byte_tokens.push_back(t);
    endfunction

    function automatic void start_token(t_mode m, logic [15:0] st);
        sc_mode = m;
        sc_start = st;
        sc_start_line = sc_line;
        sc_len = 16'd0;
    endfunction

    function automatic void word_add(logic [7:0] c);
        if (sc_len < KW_MAX_LEN) sc_chars[sc_len[3:0]] = c;
        sc_len = cap_add(sc_len, 1, CAP16);
    endfunction

    function automatic void scan_idle(logic [7:0] c);
        logic [4:0] pk;
        pk = punct_c(c);
        sc_mode = M_IDLE;
        if (c == 8'd0) begin
            add_token(K_EOF, sc_pos, 16'd0, sc_line);
            sc_pos = 16'd0; sc_line = 16'd1; sc_start = 16'd0;
            sc_start_line = 16'd1; sc_len = 16'd0;
            sc_eof = 1'b1;
        end else if (c == 8'h20 || c == 8'h09 || c == 8'h0d) begin
        end else if (c == 8'h0a) begin
            sc_line = cap_add(sc_line, 1, CAP16);
        end else if (c == 8'h22) begin
            start_token(M_STRING, cap_add(sc_pos, 1, POS_MAX));
        end else if (c == 8'h2f) begin
            start_token(M_SLASH, sc_pos);
        end else if (pk != 5'd0) begin
            add_token(pk, sc_pos, 16'd1, sc_line);
        end else if (alpha_c(c)) begin
            start_token(M_IDENT, sc_pos);
            word_add(c);
        end else if (digit_c(c)) begin
            start_token(M_NUM_INT, sc_pos);
            sc_len = 16'd1;
        end else begin
            add_token(K_ERR, sc_pos, 16'd1, sc_line);
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic        dig;
        logic [15:0] p1;
        dig = digit_c(c);
        p1 = cap_add(sc_start, int'(sc_len), POS_MAX);
        case (sc_mode)
            M_SLASH: begin
                if (c == 8'h2f) sc_mode = M_COMMENT;
                else begin
                    add_token(K_ERR, sc_start, 16'd1, sc_start_line);
                    scan_idle(c);
                end
            end
            M_COMMENT: begin
                if (c == 8'h0a) begin
                    sc_line = cap_add(sc_line, 1, CAP16);
                    sc_mode = M_IDLE;
                end else if (c == 8'd0) scan_idle(c);
            end
            M_STRING, M_STR_ESC: begin
                if (c == 8'd0 || (sc_mode == M_STRING && c == 8'h22)) begin
                    add_token(K_STR, sc_start, sc_len, sc_start_line);
                    if (c == 8'd0) scan_idle(c);
                    else sc_mode = M_IDLE;
                end else begin
                    if (sc_mode == M_STRING && c == 8'h5c) sc_mode = M_STR_ESC;
                    else if (sc_mode == M_STR_ESC) sc_mode = M_STRING;
                    else if (c == 8'h0a) sc_line = cap_add(sc_line, 1, CAP16);
                    sc_len = cap_add(sc_len, 1, CAP16);
                end
            end
            M_IDENT: begin
                if (alpha_c(c) || dig) word_add(c);
                else begin
                    add_token(word_kind(), sc_start, sc_len, sc_start_line);
                    scan_idle(c);
                end
            end
            M_NUM_INT, M_NUM_FRAC, M_NUM_EXP: begin
                if (dig) sc_len = cap_add(sc_len, 1, CAP16);
                else if (sc_mode == M_NUM_INT && c == 8'h2e) sc_mode = M_NUM_DOT;
                else if (sc_mode != M_NUM_EXP && (c == 8'h65 || c == 8'h45)) begin
                    sc_chars[0] = c;
                    sc_mode = M_NUM_E;
                end else begin
                    add_token(K_NUM, sc_start, sc_len, sc_start_line);
                    scan_idle(c);
                end
            end
            M_NUM_DOT: begin
                if (dig) begin
                    sc_len = cap_add(sc_len, 2, CAP16);
                    sc_mode = M_NUM_FRAC;
                end else begin
                    add_token(K_NUM, sc_start, sc_len, sc_start_line);
                    add_token(K_DOT, p1, 16'd1, sc_start_line);
                    scan_idle(c);
                end
            end
            M_NUM_E: begin
                if (dig) begin
                    sc_len = cap_add(sc_len, 2, CAP16);
                    sc_mode = M_NUM_EXP;
                end else if (c == 8'h2b) sc_mode = M_NUM_EPLUS;
                else if (c == 8'h2d) sc_mode = M_NUM_EMINUS;
                else begin
                    // The held e becomes the first character of an identifier.
                    add_token(K_NUM, sc_start, sc_len, sc_start_line);
                    sc_start = p1;
                    sc_len = 16'd1;
                    sc_mode = M_IDENT;
                    scan_byte(c);
                end
            end
            M_NUM_EPLUS, M_NUM_EMINUS: begin
                if (dig) begin
                    sc_len = cap_add(sc_len, 3, CAP16);
                    sc_mode = M_NUM_EXP;
                end else begin
                    add_token(K_NUM, sc_start, sc_len, sc_start_line);
                    add_token(K_IDENT, p1, 16'd1, sc_start_line);
                    add_token((sc_mode == M_NUM_EPLUS) ? K_ERR : K_MINUS,
                              cap_add(p1, 1, POS_MAX), 16'd1, sc_start_line);
                    scan_idle(c);
                end
            end
            default: scan_idle(c);
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        byte_tokens.delete();
        sc_eof = 1'b0;
        scan_byte(c);
        if (!sc_eof) sc_pos = cap_add(sc_pos, 1, POS_MAX);
        foreach (byte_tokens[i]) begin
            byte_tokens[i].last = (i == byte_tokens.size() - 1);
            pending_tokens.push_back(byte_tokens[i]);
        end
    endfunction

    // Valid is dropped only by an idle cycle or at the end of the run, so that
    // back-to-back words keep it high without a second assignment at one edge.
    task automatic send_byte(input logic [7:0] c);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_source_byte <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_byte(c);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    always @(negedge i_clk)
        i_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);

    always @(posedge i_clk) begin
        t_tok_word e;
        cycle_count++;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tokens.size() == 0) report_mismatch("token word with none expected");
            else begin
                e = pending_tokens.pop_front();
                if (o_token_kind !== e.kind || o_token_offset !== e.offset ||
                    o_token_size !== e.size || o_token_line !== e.line ||
                    o_run_last !== e.last)
                    report_mismatch($sformatf(
                        "got k%0d o%0d s%0d l%0d r%0d, want k%0d o%0d s%0d l%0d r%0d",
                        o_token_kind, o_token_offset, o_token_size, o_token_line,
                        o_run_last, e.kind, e.offset, e.size, e.line, e.last));
            end
        end
        if (cycle_count > 400000) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_text("as lens waveguides x_9\n");
        send_text("{}()[]:,.;=-+/ //c\n");
        send_text("7. 1e5 2E+3 6ex 8e+z 9e-;");
        send_text("\"a\\\"\\\nc\"");
        send_byte(8'h80); send_byte(8'd0);
        send_text("\"o\\"); send_byte(8'd0);
        send_text("//"); send_byte(8'd0);
        send_text("1e+"); send_byte(8'd0);
    endtask

    // Sends fragments and random bytes until about n have gone, then ends the source.
    task automatic test_random(input int n);
        string frags[14];
        int    stop;
        frags = '{"photon ", $sformatf("%s", KW_MESH), "x1_", "42", "3.14", "1e", "7E-2",
                  "\"s\\n\"", "// c\n", "\n", " ", "{", "-", "/"};
        stop = sent_count + n;
        while (sent_count < stop) begin
            case ($urandom_range(9, 0))
                0: send_byte(8'($urandom_range(255, 1)));
                1: if ($urandom_range(3, 0) == 0) send_byte(8'd0);
                default: send_text(frags[$urandom_range(13, 0)]);
            endcase
        end
        send_byte(8'd0);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(8);
        send_idle_pct = 67; test_random(8);
        send_idle_pct = 0; recv_stall_pct = 67; test_random(8);
        send_idle_pct = 8; recv_stall_pct = 8; test_random(8);
        wait_drained();
        if (error_count == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule

[dsl_source_tokenizer.f]
rtl/dst_pkg.sv
rtl/dst_scanner.sv
rtl/dsl_source_tokenizer.sv
bench/tb.sv
